// ----- hw/rtl/gcmp_pkg.sv -----
// Shared types, character codes and the power-of-ten table of the G-code move coordinate parser.
package gcmp_pkg;

   localparam int unsigned OUT_BITS = 32;
   localparam int unsigned BYTE_BITS = 8;

   typedef enum logic [1:0] {
      AXIS_NONE = 2'd0,
      AXIS_X    = 2'd1,
      AXIS_Y    = 2'd2,
      AXIS_Z    = 2'd3
   } axis_type;

   localparam logic [BYTE_BITS-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHAR_TAB     = 8'h09;
   localparam logic [BYTE_BITS-1:0] CHAR_CR      = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_BITS-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [BYTE_BITS-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [BYTE_BITS-1:0] CHAR_POINT   = 8'h2E;
   localparam logic [BYTE_BITS-1:0] CHAR_0       = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHAR_1       = 8'h31;
   localparam logic [BYTE_BITS-1:0] CHAR_9       = 8'h39;
   localparam logic [BYTE_BITS-1:0] CHAR_G       = 8'h47;
   localparam logic [BYTE_BITS-1:0] CHAR_X       = 8'h58;
   localparam logic [BYTE_BITS-1:0] CHAR_Y       = 8'h59;
   localparam logic [BYTE_BITS-1:0] CHAR_Z       = 8'h5A;

   localparam int unsigned POW10_BITS = 20;

   function automatic logic [POW10_BITS-1:0] pow10(input logic [2:0] n);
      logic [POW10_BITS-1:0] r;
      case (n)
         3'd0:    r = 20'd1;
         3'd1:    r = 20'd10;
         3'd2:    r = 20'd100;
         3'd3:    r = 20'd1000;
         3'd4:    r = 20'd10000;
         3'd5:    r = 20'd100000;
         3'd6:    r = 20'd1000000;
         default: r = 20'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/gcmp_if.sv -----
// Valid/ready channel interfaces for the parser's byte input and coordinate result.
interface gcmp_req_if;
   logic                             valid;
   logic                             ready;
   logic [gcmp_pkg::BYTE_BITS-1:0]   in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface gcmp_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [gcmp_pkg::OUT_BITS-1:0]  x_pos;
   logic signed [gcmp_pkg::OUT_BITS-1:0]  y_pos;
   logic signed [gcmp_pkg::OUT_BITS-1:0]  z_pos;

   modport source (output valid, output x_pos, output y_pos, output z_pos, input ready);
   modport sink (input valid, input x_pos, input y_pos, input z_pos, output ready);
endinterface

// ----- hw/rtl/gcode_move_coordinate_parser.sv -----
// G-code move coordinate parser: byte-wise line parser that reports X, Y and Z of G00/G01 lines.
//
// The req_chan channel carries one ASCII byte per transfer. The rsp_chan channel carries
// one X, Y, Z triple per transfer, in thousandths (10^-FRACTION_DIGITS) of the input unit,
// saturated to 32 bits. A result is produced for each newline that ends a line starting
// with G00 or G01; other bytes produce no result.
// Each byte updates the parser state in the cycle it is transferred, so one byte is taken
// per clock while the input is ready. The result for a newline is valid in the cycle after the newline's transfer,
// from a single output register.
// The input is ready whenever that output register is empty or is being emptied in the
// same cycle, so a stalled receiver holds the result and stops the byte stream only while
// the register is full; no result is lost.
// Reset clears the line state, the open number and the stored coordinates to zero and
// empties the output register.
module gcode_move_coordinate_parser #(
   parameter int unsigned VALUE_BITS = 32,
   parameter int unsigned FRACTION_DIGITS = 3
) (
   input logic         clock,
   input logic         reset,
   gcmp_req_if.sink    req_chan,
   gcmp_rsp_if.source  rsp_chan
);

   localparam int unsigned MW  = VALUE_BITS;
   localparam int unsigned SW  = VALUE_BITS + 25;
   localparam int unsigned FCW = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;
   localparam int unsigned WW  = ((VALUE_BITS > gcmp_pkg::OUT_BITS) ?
                                  VALUE_BITS : gcmp_pkg::OUT_BITS) + 1;

   localparam logic [SW-1:0] CAP = SW'(1) << (VALUE_BITS - 1);
   localparam logic signed [WW-1:0] OUT_MAX = (WW'(1) << (gcmp_pkg::OUT_BITS - 1)) - WW'(1);
   localparam logic signed [WW-1:0] OUT_MIN = -(WW'(1) << (gcmp_pkg::OUT_BITS - 1));

   logic [1:0]                   pos_ff, pos_in;
   logic                         hdr_ff, hdr_in;
   gcmp_pkg::axis_type           axis_ff, axis_in;
   logic [MW-1:0]                mag_ff, mag_in;
   logic                         neg_ff, neg_in;
   logic                         frac_ff, frac_in;
   logic [FCW-1:0]               fc_ff, fc_in;
   logic                         seen_ff, seen_in;
   logic signed [MW-1:0]         x_ff, x_in;
   logic signed [MW-1:0]         y_ff, y_in;
   logic signed [MW-1:0]         z_ff, z_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [gcmp_pkg::OUT_BITS-1:0] x_pos_ff, y_pos_ff, z_pos_ff;

   logic                         take;
   logic                         emit;
   logic                         do_commit;
   logic                         do_clear;
   logic [gcmp_pkg::BYTE_BITS-1:0] c;
   logic                         is_digit;
   logic [3:0]                   digit;
   logic [23:0]                  int_add;
   logic [23:0]                  frac_add;
   logic [2:0]                   frac_idx;
   logic [SW-1:0]                int_sum;
   logic [SW-1:0]                frac_sum;
   logic [SW-1:0]                mag_ext;
   logic signed [MW-1:0]         commit_val;
   logic [MW:0]                  neg_wide;

   function automatic logic signed [gcmp_pkg::OUT_BITS-1:0] clamp32(
      input logic signed [MW-1:0] v
   );
      logic signed [WW-1:0] w;
      logic signed [WW-1:0] r;
      w = WW'(v);
      if (w > OUT_MAX) begin
         r = OUT_MAX;
      end else if (w < OUT_MIN) begin
         r = OUT_MIN;
      end else begin
         r = w;
      end
      return r[gcmp_pkg::OUT_BITS-1:0];
   endfunction

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign c              = req_chan.in_byte;

   assign is_digit = (c inside {[gcmp_pkg::CHAR_0:gcmp_pkg::CHAR_9]});
   assign digit    = 4'(c - gcmp_pkg::CHAR_0);
   assign mag_ext  = SW'(mag_ff);
   assign int_add  = 24'(digit) * 24'(gcmp_pkg::pow10(3'(FRACTION_DIGITS)));
   assign frac_idx = 3'(FRACTION_DIGITS - 1) - 3'(fc_ff);
   assign frac_add = 24'(digit) * 24'(gcmp_pkg::pow10(frac_idx));
   assign int_sum  = (mag_ext << 3) + (mag_ext << 1) + SW'(int_add);
   assign frac_sum = mag_ext + SW'(frac_add);

   always_comb begin
      logic [SW-1:0] m;
      m = (mag_ext > CAP) ? CAP : mag_ext;
      neg_wide = '0;
      if (neg_ff) begin
         neg_wide   = -((MW + 1)'(m));
         commit_val = neg_wide[MW-1:0];
      end else begin
         if (m > CAP - SW'(1)) begin
            m = CAP - SW'(1);
         end
         commit_val = m[MW-1:0];
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      hdr_in    = hdr_ff;
      axis_in   = axis_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      frac_in   = frac_ff;
      fc_in     = fc_ff;
      seen_in   = seen_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      emit      = 1'b0;
      do_commit = 1'b0;
      do_clear  = 1'b0;

      if (take) begin
         if (c == gcmp_pkg::CHAR_NEWLINE) begin
            emit      = hdr_ff && (pos_ff == 2'd3);
            do_commit = emit;
            do_clear  = 1'b1;
            pos_in    = 2'd0;
            hdr_in    = 1'b0;
            axis_in   = gcmp_pkg::AXIS_NONE;
         end else begin
            if (pos_ff != 2'd3) begin
               pos_in = pos_ff + 2'd1;
            end
            case (pos_ff)
               2'd0: hdr_in = (c == gcmp_pkg::CHAR_G);
               2'd1: hdr_in = hdr_ff && (c == gcmp_pkg::CHAR_0);
               2'd2: hdr_in = hdr_ff && (c == gcmp_pkg::CHAR_0 || c == gcmp_pkg::CHAR_1);
               default: begin
                  if (hdr_ff) begin
                     if (c inside {gcmp_pkg::CHAR_SPACE, gcmp_pkg::CHAR_TAB,
                                   gcmp_pkg::CHAR_CR, gcmp_pkg::CHAR_PLUS}) begin
                        hdr_in = hdr_ff;
                     end else if (c inside {gcmp_pkg::CHAR_X, gcmp_pkg::CHAR_Y,
                                            gcmp_pkg::CHAR_Z}) begin
                        do_commit = 1'b1;
                        do_clear  = 1'b1;
                        axis_in   = gcmp_pkg::axis_type'(2'(c - gcmp_pkg::CHAR_X) + 2'd1);
                     end else if (axis_ff != gcmp_pkg::AXIS_NONE && is_digit) begin
                        if (!frac_ff) begin
                           mag_in  = (int_sum > CAP) ? CAP[MW-1:0] : int_sum[MW-1:0];
                           seen_in = 1'b1;
                        end else if (fc_ff < FCW'(FRACTION_DIGITS)) begin
                           mag_in  = (frac_sum > CAP) ? CAP[MW-1:0] : frac_sum[MW-1:0];
                           fc_in   = fc_ff + FCW'(1);
                           seen_in = 1'b1;
                        end
                     end else if (axis_ff != gcmp_pkg::AXIS_NONE &&
                                  c == gcmp_pkg::CHAR_POINT && !frac_ff) begin
                        frac_in = 1'b1;
                     end else if (axis_ff != gcmp_pkg::AXIS_NONE &&
                                  c == gcmp_pkg::CHAR_MINUS && !seen_ff &&
                                  !frac_ff && !neg_ff) begin
                        neg_in = 1'b1;
                     end else begin
                        do_commit = 1'b1;
                        do_clear  = 1'b1;
                        axis_in   = gcmp_pkg::AXIS_NONE;
                     end
                  end
               end
            endcase
         end

         if (do_commit && seen_ff) begin
            case (axis_ff)
               gcmp_pkg::AXIS_X: x_in = commit_val;
               gcmp_pkg::AXIS_Y: y_in = commit_val;
               gcmp_pkg::AXIS_Z: z_in = commit_val;
               default: x_in = x_ff;
            endcase
         end

         if (do_clear) begin
            mag_in  = '0;
            neg_in  = 1'b0;
            frac_in = 1'b0;
            fc_in   = '0;
            seen_in = 1'b0;
         end
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 2'd0;
         hdr_ff       <= 1'b0;
         axis_ff      <= gcmp_pkg::AXIS_NONE;
         mag_ff       <= '0;
         neg_ff       <= 1'b0;
         frac_ff      <= 1'b0;
         fc_ff        <= '0;
         seen_ff      <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         z_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         hdr_ff       <= hdr_in;
         axis_ff      <= axis_in;
         mag_ff       <= mag_in;
         neg_ff       <= neg_in;
         frac_ff      <= frac_in;
         fc_ff        <= fc_in;
         seen_ff      <= seen_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         x_pos_ff <= clamp32(x_in);
         y_pos_ff <= clamp32(y_in);
         z_pos_ff <= clamp32(z_in);
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.x_pos = x_pos_ff;
   assign rsp_chan.y_pos = y_pos_ff;
   assign rsp_chan.z_pos = z_pos_ff;

endmodule

// ----- tb/sv/gcmp_move_checker.sv -----
`timescale 1ns / 1ps
// Monitor that predicts the parser's coordinate results from the byte stream and compares them.
module gcmp_move_checker #(
   parameter int unsigned VALUE_BITS = 32,
   parameter int unsigned FRACTION_DIGITS = 3
) (
   input  logic        clock,
   input  logic        reset,
   gcmp_req_if         req_mon,
   gcmp_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned moves_waiting
);

   typedef struct packed {
      logic signed [gcmp_pkg::OUT_BITS-1:0] x;
      logic signed [gcmp_pkg::OUT_BITS-1:0] y;
      logic signed [gcmp_pkg::OUT_BITS-1:0] z;
   } coord_type;

   localparam longint unsigned MAG_CAP = 64'd1 << (VALUE_BITS - 1);
   localparam longint OUT_MAX = (longint'(1) << (gcmp_pkg::OUT_BITS - 1)) - 1;
   localparam longint OUT_MIN = -OUT_MAX - 1;

   coord_type move_q[$];

   logic [1:0]                           char_pos;
   bit                                   hdr_ok;
   gcmp_pkg::axis_type                   cur_axis;
   longint unsigned                      mag;
   bit                                   neg;
   bit                                   frac_mode;
   int unsigned                          frac_cnt;
   bit                                   have_digit;
   logic signed [gcmp_pkg::OUT_BITS-1:0] x_val;
   logic signed [gcmp_pkg::OUT_BITS-1:0] y_val;
   logic signed [gcmp_pkg::OUT_BITS-1:0] z_val;

   function automatic longint unsigned scale10(input int unsigned n);
      longint unsigned r;
      r = 1;
      repeat (n) r = r * 10;
      return r;
   endfunction

   function automatic void clear_number();
      mag = 0;
      neg = 1'b0;
      frac_mode = 1'b0;
      frac_cnt = 0;
      have_digit = 1'b0;
   endfunction

   // Stores the open number into its axis, saturated, and closes the word.
   function automatic void close_number();
      longint unsigned m;
      longint v;
      m = mag;
      if (cur_axis != gcmp_pkg::AXIS_NONE && have_digit) begin
         if (neg) begin
            if (m > MAG_CAP) m = MAG_CAP;
            v = -longint'(m);
         end else begin
            if (m > MAG_CAP - 1) m = MAG_CAP - 1;
            v = longint'(m);
         end
         if (v > OUT_MAX) v = OUT_MAX;
         if (v < OUT_MIN) v = OUT_MIN;
         case (cur_axis)
            gcmp_pkg::AXIS_X: x_val = v[gcmp_pkg::OUT_BITS-1:0];
            gcmp_pkg::AXIS_Y: y_val = v[gcmp_pkg::OUT_BITS-1:0];
            default: z_val = v[gcmp_pkg::OUT_BITS-1:0];
         endcase
      end
      cur_axis = gcmp_pkg::AXIS_NONE;
      clear_number();
   endfunction

   function automatic void take_digit(input logic [gcmp_pkg::BYTE_BITS-1:0] c);
      longint unsigned d;
      longint unsigned add;
      d = c - gcmp_pkg::CHAR_0;
      if (!frac_mode) begin
         add = d * scale10(FRACTION_DIGITS);
         if (mag > (MAG_CAP - add) / 10) mag = MAG_CAP;
         else mag = mag * 10 + add;
         have_digit = 1'b1;
      end else if (frac_cnt < FRACTION_DIGITS) begin
         add = d * scale10(FRACTION_DIGITS - 1 - frac_cnt);
         frac_cnt++;
         if (mag > MAG_CAP - add) mag = MAG_CAP;
         else mag = mag + add;
         have_digit = 1'b1;
      end
   endfunction

   function automatic void parse_char(input logic [gcmp_pkg::BYTE_BITS-1:0] c);
      bit emit;
      coord_type mv;
      if (c == gcmp_pkg::CHAR_NEWLINE) begin
         emit = hdr_ok && char_pos == 2'd3;
         if (emit) close_number();
         char_pos = 0;
         hdr_ok = 1'b0;
         cur_axis = gcmp_pkg::AXIS_NONE;
         clear_number();
         if (emit) begin
            mv = '{x: x_val, y: y_val, z: z_val};
            move_q.insert(move_q.size(), mv);
         end
      end else begin
         case (char_pos)
            2'd0: hdr_ok = (c == gcmp_pkg::CHAR_G);
            2'd1: hdr_ok = hdr_ok && c == gcmp_pkg::CHAR_0;
            2'd2: hdr_ok = hdr_ok && (c == gcmp_pkg::CHAR_0 || c == gcmp_pkg::CHAR_1);
            default: begin
               if (hdr_ok) begin
                  if (c inside {gcmp_pkg::CHAR_SPACE, gcmp_pkg::CHAR_TAB,
                                gcmp_pkg::CHAR_CR, gcmp_pkg::CHAR_PLUS}) begin
                  end else if (c == gcmp_pkg::CHAR_X || c == gcmp_pkg::CHAR_Y ||
                               c == gcmp_pkg::CHAR_Z) begin
                     close_number();
                     cur_axis = (c == gcmp_pkg::CHAR_X) ? gcmp_pkg::AXIS_X :
                                (c == gcmp_pkg::CHAR_Y) ? gcmp_pkg::AXIS_Y : gcmp_pkg::AXIS_Z;
                  end else if (cur_axis != gcmp_pkg::AXIS_NONE && c >= gcmp_pkg::CHAR_0 &&
                               c <= gcmp_pkg::CHAR_9) begin
                     take_digit(c);
                  end else if (cur_axis != gcmp_pkg::AXIS_NONE &&
                               c == gcmp_pkg::CHAR_POINT && !frac_mode) begin
                     frac_mode = 1'b1;
                  end else if (cur_axis != gcmp_pkg::AXIS_NONE &&
                               c == gcmp_pkg::CHAR_MINUS && !have_digit &&
                               !frac_mode && !neg) begin
                     neg = 1'b1;
                  end else begin
                     close_number();
                  end
               end
            end
         endcase
         if (char_pos != 2'd3) char_pos++;
      end
   endfunction

   function automatic void check_axis(input string name,
                                      input logic signed [gcmp_pkg::OUT_BITS-1:0] want,
                                      input logic signed [gcmp_pkg::OUT_BITS-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      coord_type want;
      if (reset) begin
         char_pos = 0;
         hdr_ok = 1'b0;
         cur_axis = gcmp_pkg::AXIS_NONE;
         clear_number();
         x_val = 0;
         y_val = 0;
         z_val = 0;
         move_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (move_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, got x=%0d y=%0d z=%0d",
                        $time, rsp_mon.x_pos, rsp_mon.y_pos, rsp_mon.z_pos);
            end else begin
               want = move_q.pop_front();
               check_axis("x_pos", want.x, rsp_mon.x_pos);
               check_axis("y_pos", want.y, rsp_mon.y_pos);
               check_axis("z_pos", want.z, rsp_mon.z_pos);
            end
         end
         if (req_mon.valid && req_mon.ready) parse_char(req_mon.in_byte);
      end
      moves_waiting = move_q.size();
   end

endmodule

// ----- tb/sv/gcode_move_coordinate_parser_test.sv -----
`timescale 1ns / 1ps
// Top of the parser testbench: clock, reset, G-code byte stimulus, receiver stalls and verdict.
module gcode_move_coordinate_parser_test;

   localparam int unsigned VALUE_BITS = 32;
   localparam int unsigned FRACTION_DIGITS = 3;
   localparam int unsigned PHASE_BYTES = 340;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned BYTE_W = gcmp_pkg::BYTE_BITS;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned moves_waiting;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   bit          hold_req;
   bit          hold_done;
   logic [gcmp_pkg::BYTE_BITS-1:0] text_q[$];

   gcmp_req_if req_chan();
   gcmp_rsp_if rsp_chan();

   gcode_move_coordinate_parser #(
      .VALUE_BITS(VALUE_BITS),
      .FRACTION_DIGITS(FRACTION_DIGITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   gcmp_move_checker #(
      .VALUE_BITS(VALUE_BITS),
      .FRACTION_DIGITS(FRACTION_DIGITS)
   ) move_check (
      .clock(clock),
      .reset(reset),
      .req_mon(req_chan),
      .rsp_mon(rsp_chan),
      .fail_count(fail_count),
      .moves_waiting(moves_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // A long hold-off is counted here so that the sender keeps offering bytes meanwhile.
   initial begin
      rsp_chan.ready = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_byte(input logic [gcmp_pkg::BYTE_BITS-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.in_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_text();
      while (text_q.size() != 0) send_byte(text_q.pop_front());
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (moves_waiting != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic void put_byte(input logic [gcmp_pkg::BYTE_BITS-1:0] b);
      text_q.insert(text_q.size(), b);
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endfunction

   function automatic void add_blanks();
      string pool;
      pool = " \t\r";
      while ($urandom_range(3) == 0) put_byte(pool[$urandom_range(2)]);
   endfunction

   function automatic void add_digits(input int unsigned n);
      repeat (n) put_byte(gcmp_pkg::CHAR_0 + BYTE_W'($urandom_range(9)));
   endfunction

   function automatic void add_number();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 3) add_text("-");
      else if (r == 3) add_text("+");
      else if (r == 4) add_text("-+");
      r = $urandom_range(99);
      if (r < 5) add_digits(0);
      else if (r < 85) add_digits($urandom_range(1, 4));
      else add_digits($urandom_range(6, 11));
      if ($urandom_range(1)) begin
         add_text(".");
         add_digits($urandom_range(0, 5));
      end
   endfunction

   // Mostly well-formed move lines with random words; the rest carry broken headers,
   // stray characters, raw bytes or a missing newline.
   function automatic void add_line();
      int unsigned kind;
      string hdr_pool;
      string junk_pool;
      hdr_pool = "G01gX2 -";
      junk_pool = ".-+aFx#G";
      kind = $urandom_range(99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 8)) put_byte(BYTE_W'($urandom_range(255)));
         put_byte(gcmp_pkg::CHAR_NEWLINE);
         return;
      end
      if (kind < 14) begin
         repeat (3) put_byte(hdr_pool[$urandom_range(7)]);
      end else if (kind < 16) begin
         add_text("G0");
         put_byte(gcmp_pkg::CHAR_NEWLINE);
         return;
      end else begin
         add_text("G0");
         put_byte($urandom_range(1) ? gcmp_pkg::CHAR_1 : gcmp_pkg::CHAR_0);
         if (kind < 18) begin
            put_byte(gcmp_pkg::CHAR_NEWLINE);
            return;
         end
      end
      repeat ($urandom_range(0, 4)) begin
         add_blanks();
         case ($urandom_range(2))
            0: add_text("X");
            1: add_text("Y");
            default: add_text("Z");
         endcase
         add_blanks();
         add_number();
         if ($urandom_range(99) < 10) begin
            if ($urandom_range(1)) put_byte(junk_pool[$urandom_range(7)]);
            else put_byte(BYTE_W'($urandom_range(255)));
            add_digits($urandom_range(0, 2));
         end
         if ($urandom_range(99) < 8) begin
            add_text("F");
            add_digits($urandom_range(1, 4));
         end
      end
      add_blanks();
      if (kind < 96) put_byte(gcmp_pkg::CHAR_NEWLINE);
   endfunction

   initial begin
      req_chan.valid = 1'b0;
      req_chan.in_byte = '0;
      reset = 1'b1;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_req = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_text("G01X2147483.648Y-2147483.648Z-.0009\n");
      add_text("G00 X-99999999 Z\tF12\n");
      add_text("G10X1\n");
      send_text();
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         if (phase == 0) hold_req = 1'b1;
         while (text_q.size() < PHASE_BYTES) add_line();
         send_text();
         drain();
      end

      // The final line has no newline and must never produce a result.
      add_text("G00X5");
      send_text();
      drain();
      repeat (20) @(posedge clock);

      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
